// ===== design/h5sf_pkg.sv =====
// Shared types and constants for the H5 SLIP transmit framer.
// No dependencies; used by h5sf_burst_builder and the core.
package h5sf_pkg;

    localparam logic [7:0] SLIP_DELIM       = 8'hC0;
    localparam logic [7:0] SLIP_STUFF       = 8'hDB;
    localparam logic [7:0] SLIP_CODE_DELIM  = 8'hDC;
    localparam logic [7:0] SLIP_CODE_STUFF  = 8'hDD;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_RESET   = 2'd2;

    localparam logic [3:0] PTYPE_CMD = 4'd1;
    localparam logic [3:0] PTYPE_ACL = 4'd2;

    // up to six line "slots" per request; an escaped slot yields two bytes
    localparam int unsigned MAX_ENTRIES = 6;

    typedef struct packed {
        logic [7:0] first;   // byte sent first (ESC when escaped)
        logic [7:0] second;  // stuffed code byte, used only when esc is set
        logic       esc;
        logic       fend;    // closing delimiter of a frame
    } entry_t;

    typedef entry_t [MAX_ENTRIES-1:0] entry_vec_t;

    typedef struct packed {
        entry_vec_t  entries;
        logic [2:0]  count;
    } burst_t;

    function automatic entry_t mk_raw(input logic [7:0] b, input logic fend);
        entry_t e;
        e.first  = b;
        e.second = SLIP_CODE_STUFF;
        e.esc    = 1'b0;
        e.fend   = fend;
        return e;
    endfunction

    function automatic entry_t mk_escaped(input logic [7:0] b);
        entry_t e;
        e.fend = 1'b0;
        if (b == SLIP_DELIM) begin
            e.first  = SLIP_STUFF;
            e.second = SLIP_CODE_DELIM;
            e.esc    = 1'b1;
        end else if (b == SLIP_STUFF) begin
            e.first  = SLIP_STUFF;
            e.second = SLIP_CODE_STUFF;
            e.esc    = 1'b1;
        end else begin
            e.first  = b;
            e.second = SLIP_CODE_STUFF;
            e.esc    = 1'b0;
        end
        return e;
    endfunction

endpackage

// ===== design/h5sf_burst_builder.sv =====
// Combinational request decoder: header, checksum, SLIP slots, next framer state.
// Depends on h5sf_pkg.
module h5sf_burst_builder #(
    parameter int LENGTH_BITS = 12
) (
    input  logic [1:0]             kind,
    input  logic [3:0]             packet_type,
    input  logic [11:0]            payload_length,
    input  logic [2:0]             ack_number,
    input  logic [7:0]             data_byte,
    input  logic [2:0]             seq,
    input  logic                   frame_open,
    input  logic [LENGTH_BITS-1:0] bytes_remaining,
    output h5sf_pkg::burst_t       burst,
    output logic [2:0]             seq_next,
    output logic                   frame_open_next,
    output logic [LENGTH_BITS-1:0] bytes_remaining_next
);

    logic [11:0]            len_w;
    logic                   reliable;
    logic [7:0]             h0, h1, h2, hck;
    logic [9:0]             hsum;
    logic [LENGTH_BITS-1:0] rem_dec;

    always_comb begin
        len_w = '0;
        len_w[LENGTH_BITS-1:0] = payload_length[LENGTH_BITS-1:0];
        reliable = (packet_type == h5sf_pkg::PTYPE_CMD) ||
                   (packet_type == h5sf_pkg::PTYPE_ACL);
        h0   = {reliable, 1'b0, ack_number, seq & {3{reliable}}};
        h1   = {len_w[3:0], packet_type};
        h2   = len_w[11:4];
        hsum = 10'(h0) + 10'(h1) + 10'(h2);
        hck  = ~hsum[7:0];
        rem_dec = bytes_remaining - LENGTH_BITS'(1);

        burst.entries        = '0;
        burst.count          = '0;
        seq_next             = seq;
        frame_open_next      = frame_open;
        bytes_remaining_next = bytes_remaining;

        case (kind)
            h5sf_pkg::KIND_START: begin
                burst.entries[0] = h5sf_pkg::mk_raw(h5sf_pkg::SLIP_DELIM, 1'b0);
                burst.entries[1] = h5sf_pkg::mk_escaped(h0);
                burst.entries[2] = h5sf_pkg::mk_escaped(h1);
                burst.entries[3] = h5sf_pkg::mk_escaped(h2);
                burst.entries[4] = h5sf_pkg::mk_escaped(hck);
                burst.entries[5] = h5sf_pkg::mk_raw(h5sf_pkg::SLIP_DELIM, 1'b1);
                if (reliable) begin
                    seq_next = seq + 3'd1;
                end
                if (len_w == '0) begin
                    burst.count     = 3'd6;
                    frame_open_next = 1'b0;
                end else begin
                    burst.count     = 3'd5;
                    frame_open_next = 1'b1;
                end
                bytes_remaining_next = len_w[LENGTH_BITS-1:0];
            end
            h5sf_pkg::KIND_PAYLOAD: begin
                if (frame_open) begin
                    burst.entries[0] = h5sf_pkg::mk_escaped(data_byte);
                    burst.entries[1] = h5sf_pkg::mk_raw(h5sf_pkg::SLIP_DELIM, 1'b1);
                    bytes_remaining_next = rem_dec;
                    if (rem_dec == '0) begin
                        burst.count     = 3'd2;
                        frame_open_next = 1'b0;
                    end else begin
                        burst.count = 3'd1;
                    end
                end
            end
            h5sf_pkg::KIND_RESET: begin
                seq_next = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/h5_transmit_slip_framer_core.sv =====
// H5 three-wire UART transmit framer core: SLIP-escaped frame byte stream.
// The first line byte is valid in the cycle after the request is accepted.
// Throughput: one line byte per cycle while m_tready is high; a request yields
// 1..10 line bytes, or none (reset, or payload with no open frame), on the single
// byte-wide output port. Sync active-low reset clears the sequence counter,
// open-frame state, remaining count and the output queue.
module h5_transmit_slip_framer_core #(
    parameter int LENGTH_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [3:0] packet_type, [15:4] payload_length,
                                   // [18:16] ack_number, [26:19] data_byte, rest 0
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] line_byte
    output logic        m_tuser,   // [0] frame_end
    output logic        m_tlast    // run_last: final byte of this request
);

    // framer state
    logic [2:0]             seq_reg, seq_next;
    logic                   open_reg, open_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;

    // output slot queue: slot 0 is on the wire, phase picks the stuffed byte
    h5sf_pkg::entry_vec_t   ent_reg, ent_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic                   phase_reg, phase_next;

    h5sf_pkg::burst_t       burst;
    h5sf_pkg::entry_t       cur;
    logic                   take, ent_done, accept;

    h5sf_burst_builder #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_builder (
        .kind                 (s_tuser),
        .packet_type          (s_tdata[3:0]),
        .payload_length       (s_tdata[15:4]),
        .ack_number           (s_tdata[18:16]),
        .data_byte            (s_tdata[26:19]),
        .seq                  (seq_reg),
        .frame_open           (open_reg),
        .bytes_remaining      (rem_reg),
        .burst                (burst),
        .seq_next             (seq_next),
        .frame_open_next      (open_next),
        .bytes_remaining_next (rem_next)
    );

    assign cur      = ent_reg[0];
    assign ent_done = !cur.esc || phase_reg;
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = phase_reg ? cur.second : cur.first;
    assign m_tuser  = cur.fend;
    assign m_tlast  = (cnt_reg == 3'd1) && ent_done;
    assign take     = m_tvalid && m_tready;

    // next request may load while the last byte of the current one leaves
    assign s_tready = (cnt_reg == 3'd0) || (take && m_tlast);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ent_next   = ent_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (take) begin
            if (ent_done) begin
                for (int i = 0; i < h5sf_pkg::MAX_ENTRIES - 1; i++) begin
                    ent_next[i] = ent_reg[i+1];
                end
                cnt_next   = cnt_reg - 3'd1;
                phase_next = 1'b0;
            end else begin
                phase_next = 1'b1;
            end
        end
        if (accept && burst.count != 3'd0) begin
            ent_next   = burst.entries;
            cnt_next   = burst.count;
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        if (!aresetn) begin
            seq_reg   <= '0;
            open_reg  <= 1'b0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            if (accept) begin
                seq_reg  <= seq_next;
                open_reg <= open_next;
                rem_reg  <= rem_next;
            end
        end
    end

endmodule
